// File: rtl/core/atqi_pkg.sv
// ----------------------------------------------------------------------------
// atqi_pkg
// Shared constants and the CORDIC arctangent table for the tilt-to-quaternion
// initializer.
// ----------------------------------------------------------------------------
package atqi_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned QUAT_W   = 16;
  localparam int unsigned SUM_W    = 33;
  localparam int unsigned COUNT_W  = 16;

  localparam logic [COUNT_W-1:0] MAX_SAMPLES = 16'd65535;

  localparam int unsigned CORDIC_ITERATIONS = 16;
  localparam int unsigned ITER_W            = 5;

  // round(65536 * 32768 / pi)
  localparam logic [31:0] RAD_TO_BAM = 32'd683565276;
  // CORDIC gain 0.6072529350 in Q2.30
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/accel_tilt_quaternion_init.sv
// Work per sample word: two 17-step restoring divisions, three 16-step CORDIC
//   rotations and twelve multiply/accumulate passes through one shared
//   multiplier; the division steps are skipped when the z sum is zero. A
//   restart word goes straight to the result stage.
// Flow: in_ready is high only while idle, so no word is taken mid-run.
// Reset (rst, synchronous): sums, count and output valid cleared.
// ----------------------------------------------------------------------------
// accel_tilt_quaternion_init
// Averages accelerometer samples, turns the small-angle tilt ratios into roll
// and pitch, and converts roll, pitch and heading to a Q2.14 quaternion.
// ----------------------------------------------------------------------------
module accel_tilt_quaternion_init (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 cmd,
  input  logic signed [atqi_pkg::SAMPLE_W-1:0] accel_x,
  input  logic signed [atqi_pkg::SAMPLE_W-1:0] accel_y,
  input  logic signed [atqi_pkg::SAMPLE_W-1:0] accel_z,
  input  logic signed [atqi_pkg::SAMPLE_W-1:0] heading,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [atqi_pkg::QUAT_W-1:0]   quat_w,
  output logic signed [atqi_pkg::QUAT_W-1:0]   quat_x,
  output logic signed [atqi_pkg::QUAT_W-1:0]   quat_y,
  output logic signed [atqi_pkg::QUAT_W-1:0]   quat_z,
  output logic                                 tilt_saturated
);
  import atqi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_MUL, S_DIV_LOAD, S_DIV_STEP, S_DIV_DONE,
    S_CORD_INIT, S_CORD_STEP, S_CORD_DONE, S_MUL, S_ACC, S_FINISH
  } state_t;

  state_t state;

  logic signed [SUM_W-1:0]   sum_x, sum_y, sum_z;
  logic [COUNT_W-1:0]        sample_count;
  logic signed [15:0]        heading_r;
  logic                      restart_r;
  logic                      sat;

  // divider
  logic                      ang_sel;
  logic [63:0]               rem;
  logic [63:0]               dsh;
  logic [15:0]               quo;
  logic [4:0]                dstep;
  logic                      ovf;
  logic signed [15:0]        roll, pitch;

  // CORDIC
  logic signed [33:0]        cx, cy_r, cz;
  logic [ITER_W-1:0]         citer;
  logic [1:0]                csel;
  logic signed [17:0]        cosv [3];
  logic signed [17:0]        sinv [3];

  // shared multiplier and accumulators
  logic signed [35:0]        mul_a;
  logic signed [31:0]        mul_b;
  logic signed [67:0]        mprod;
  logic [3:0]                pstep;
  logic signed [35:0]        pair [4];
  logic signed [55:0]        acc [4];

  // combinational helpers
  logic signed [SUM_W-1:0]   num;
  logic signed [SUM_W-1:0]   num_abs, den_abs;
  logic [31:0]               num_mag, den_mag;
  logic                      ge;
  logic signed [15:0]        ang;
  logic                      ang_sat;
  logic signed [15:0]        cord_ang;
  logic signed [33:0]        dx, dy, atan_s;
  logic signed [33:0]        x_rnd, y_rnd;
  logic [1:0]                acc_idx;
  logic                      acc_sub;

  function automatic logic signed [15:0] to_q14(input logic signed [55:0] a);
    logic signed [55:0] v;
    v = (a + 56'sd8589934592) >>> 34;
    if (v > 56'sd16384) begin
      v = 56'sd16384;
    end else if (v < -56'sd16384) begin
      v = -56'sd16384;
    end
    return v[15:0];
  endfunction

  assign in_ready = (state == S_IDLE);

  assign num     = ang_sel ? sum_x : sum_y;
  assign num_abs = num[SUM_W-1] ? -num : num;
  assign den_abs = sum_z[SUM_W-1] ? -sum_z : sum_z;
  assign num_mag = num_abs[31:0];
  assign den_mag = den_abs[31:0];
  assign ge      = (rem >= dsh);

  // angle resolution after a division
  always_comb begin
    ang     = '0;
    ang_sat = 1'b0;
    if (sum_z == '0) begin
      ang_sat = 1'b1;
      ang     = num[SUM_W-1] ? -16'sd32768 : 16'sd32767;
    end else if (num[SUM_W-1] ^ sum_z[SUM_W-1]) begin
      if (ovf || quo > 16'd32768) begin
        ang_sat = 1'b1;
        ang     = -16'sd32768;
      end else begin
        ang = 16'(-$signed({1'b0, quo}));
      end
    end else begin
      if (ovf || quo > 16'd32767) begin
        ang_sat = 1'b1;
        ang     = 16'sd32767;
      end else begin
        ang = $signed(quo);
      end
    end
  end

  always_comb begin
    unique case (csel)
      2'd0:    cord_ang = roll;
      2'd1:    cord_ang = pitch;
      default: cord_ang = heading_r;
    endcase
  end

  assign dx     = cy_r >>> citer;
  assign dy     = cx >>> citer;
  assign atan_s = $signed({2'b00, atan_turn(citer)});
  assign x_rnd  = (cx + 34'sd8192) >>> 14;
  assign y_rnd  = (cy_r + 34'sd8192) >>> 14;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_DIV_MUL) begin
      mul_a = $signed({4'b0000, num_mag});
      mul_b = $signed(RAD_TO_BAM);
    end else begin
      case (pstep)
        4'd0:  begin mul_a = 36'(cosv[0]); mul_b = 32'(cosv[1]); end
        4'd1:  begin mul_a = 36'(sinv[0]); mul_b = 32'(sinv[1]); end
        4'd2:  begin mul_a = 36'(sinv[0]); mul_b = 32'(cosv[1]); end
        4'd3:  begin mul_a = 36'(cosv[0]); mul_b = 32'(sinv[1]); end
        4'd4:  begin mul_a = pair[0]; mul_b = 32'(cosv[2]); end
        4'd5:  begin mul_a = pair[1]; mul_b = 32'(sinv[2]); end
        4'd6:  begin mul_a = pair[2]; mul_b = 32'(cosv[2]); end
        4'd7:  begin mul_a = pair[3]; mul_b = 32'(sinv[2]); end
        4'd8:  begin mul_a = pair[3]; mul_b = 32'(cosv[2]); end
        4'd9:  begin mul_a = pair[2]; mul_b = 32'(sinv[2]); end
        4'd10: begin mul_a = pair[0]; mul_b = 32'(sinv[2]); end
        default: begin mul_a = pair[1]; mul_b = 32'(cosv[2]); end
      endcase
    end
  end

  // which component a triple product lands in, and its sign
  always_comb begin
    case (pstep)
      4'd4, 4'd5:   begin acc_idx = 2'd0; acc_sub = 1'b0; end
      4'd6:         begin acc_idx = 2'd1; acc_sub = 1'b0; end
      4'd7:         begin acc_idx = 2'd1; acc_sub = 1'b1; end
      4'd8, 4'd9:   begin acc_idx = 2'd2; acc_sub = 1'b0; end
      4'd10:        begin acc_idx = 2'd3; acc_sub = 1'b0; end
      4'd11:        begin acc_idx = 2'd3; acc_sub = 1'b1; end
      default:      begin acc_idx = 2'd0; acc_sub = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    mprod <= 68'(mul_a) * 68'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sum_x        <= '0;
      sum_y        <= '0;
      sum_z        <= '0;
      sample_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            heading_r <= heading;
            restart_r <= cmd;
            sat       <= 1'b0;
            ang_sel   <= 1'b0;
            if (cmd) begin
              sum_x        <= '0;
              sum_y        <= '0;
              sum_z        <= '0;
              sample_count <= '0;
              state        <= S_FINISH;
            end else begin
              if (sample_count < MAX_SAMPLES) begin
                sum_x        <= sum_x + SUM_W'(accel_x);
                sum_y        <= sum_y + SUM_W'(accel_y);
                sum_z        <= sum_z + SUM_W'(accel_z);
                sample_count <= sample_count + 1'b1;
              end
              state <= S_DIV_MUL;
            end
          end
        end
        S_DIV_MUL: begin
          state <= S_DIV_LOAD;
        end
        S_DIV_LOAD: begin
          // numerator carries half the divisor for round-half-up
          rem   <= mprod[63:0] + 64'({den_mag, 15'b0});
          dsh   <= {den_mag, 32'b0};
          dstep <= 5'd16;
          quo   <= '0;
          ovf   <= 1'b0;
          state <= (sum_z == '0) ? S_DIV_DONE : S_DIV_STEP;
        end
        S_DIV_STEP: begin
          if (ge) begin
            rem <= rem - dsh;
          end
          quo   <= {quo[14:0], ge};
          dsh   <= dsh >> 1;
          dstep <= dstep - 1'b1;
          if (dstep == 5'd16 && ge) begin
            ovf   <= 1'b1;
            state <= S_DIV_DONE;
          end else if (dstep == 5'd0) begin
            state <= S_DIV_DONE;
          end
        end
        S_DIV_DONE: begin
          sat <= sat | ang_sat;
          if (!ang_sel) begin
            roll    <= ang;
            ang_sel <= 1'b1;
            state   <= S_DIV_MUL;
          end else begin
            pitch <= ang;
            csel  <= 2'd0;
            state <= S_CORD_INIT;
          end
        end
        S_CORD_INIT: begin
          cx    <= CORDIC_X0;
          cy_r  <= '0;
          cz    <= 34'(cord_ang) <<< 15;
          citer <= '0;
          state <= S_CORD_STEP;
        end
        S_CORD_STEP: begin
          if (!cz[33]) begin
            cx   <= cx - dx;
            cy_r <= cy_r + dy;
            cz   <= cz - atan_s;
          end else begin
            cx   <= cx + dx;
            cy_r <= cy_r - dy;
            cz   <= cz + atan_s;
          end
          citer <= citer + 1'b1;
          if (citer == ITER_W'(CORDIC_ITERATIONS - 1)) begin
            state <= S_CORD_DONE;
          end
        end
        S_CORD_DONE: begin
          cosv[csel] <= x_rnd[17:0];
          sinv[csel] <= y_rnd[17:0];
          if (csel == 2'd2) begin
            pstep <= '0;
            for (int k = 0; k < 4; k++) begin
              acc[k] <= '0;
            end
            state <= S_MUL;
          end else begin
            csel  <= csel + 1'b1;
            state <= S_CORD_INIT;
          end
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (pstep < 4'd4) begin
            pair[pstep[1:0]] <= mprod[35:0];
          end else if (acc_sub) begin
            acc[acc_idx] <= acc[acc_idx] - mprod[55:0];
          end else begin
            acc[acc_idx] <= acc[acc_idx] + mprod[55:0];
          end
          pstep <= pstep + 1'b1;
          state <= (pstep == 4'd11) ? S_FINISH : S_MUL;
        end
        S_FINISH: begin
          // hold until the previous result word has left
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            if (restart_r) begin
              quat_w         <= '0;
              quat_x         <= '0;
              quat_y         <= '0;
              quat_z         <= '0;
              tilt_saturated <= 1'b0;
            end else begin
              quat_w         <= to_q14(acc[0]);
              quat_x         <= to_q14(acc[1]);
              quat_y         <= to_q14(acc[2]);
              quat_z         <= to_q14(acc[3]);
              tilt_saturated <= sat;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/atqi_checker.sv
// ----------------------------------------------------------------------------
// atqi_checker
// Port-level checks for the tilt-to-quaternion initializer.
// ----------------------------------------------------------------------------
module atqi_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 cmd,
  input logic signed [atqi_pkg::SAMPLE_W-1:0] accel_x,
  input logic signed [atqi_pkg::SAMPLE_W-1:0] accel_y,
  input logic signed [atqi_pkg::SAMPLE_W-1:0] accel_z,
  input logic signed [atqi_pkg::SAMPLE_W-1:0] heading,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [atqi_pkg::QUAT_W-1:0]   quat_w,
  input logic signed [atqi_pkg::QUAT_W-1:0]   quat_x,
  input logic signed [atqi_pkg::QUAT_W-1:0]   quat_y,
  input logic signed [atqi_pkg::QUAT_W-1:0]   quat_z,
  input logic                                 tilt_saturated
);

  // busy after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an accepted word");

  // a restart word taken with no result waiting yields an all-zero result
  a_restart_zero: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd && !out_valid |=> ##1
      (out_valid && quat_w == '0 && quat_x == '0 && quat_y == '0 && quat_z == '0
       && !tilt_saturated))
    else $error("restart did not give a zero result");

  a_w_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (quat_w <= 16'sd16384 && quat_w >= -16'sd16384))
    else $error("quat_w out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quat_w) && $stable(quat_z))
    else $error("result word changed while stalled");

endmodule

bind accel_tilt_quaternion_init atqi_checker u_atqi_checker (.*);

// File: dv/tb_accel_tilt_quaternion_init.sv
// ----------------------------------------------------------------------------
// Testbench for accel_tilt_quaternion_init
// Sends restart and sample words with random gaps and output back-pressure,
// keeps a bit-exact model of the running sums, tilt angles, CORDIC and
// quaternion math, and compares every result word against it.
// ----------------------------------------------------------------------------
module tb_accel_tilt_quaternion_init;
  timeunit 1ns;
  timeprecision 1ps;

  import atqi_pkg::*;

  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;
  localparam int   STALL_LIMIT = 6000;
  localparam longint unsigned BAM_SCALE = 64'd683565276;
  localparam longint GAIN_X0 = 64'sd652032874;

  typedef struct packed {
    logic signed [QUAT_W-1:0] w;
    logic signed [QUAT_W-1:0] x;
    logic signed [QUAT_W-1:0] y;
    logic signed [QUAT_W-1:0] z;
    logic                     sat;
  } attitude_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = CMD_SAMPLE;
  logic signed [SAMPLE_W-1:0] accel_x = '0;
  logic signed [SAMPLE_W-1:0] accel_y = '0;
  logic signed [SAMPLE_W-1:0] accel_z = '0;
  logic signed [SAMPLE_W-1:0] heading = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [QUAT_W-1:0] quat_w, quat_x, quat_y, quat_z;
  logic tilt_saturated;

  accel_tilt_quaternion_init uut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // model state
  longint sum_acc[3];
  int unsigned n_samples;
  attitude_t pending_attitudes[$];
  int mismatches = 0;
  int idle_cycles = 0;

  longint atan_lut[16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D};

  function automatic longint tilt_angle(longint num, longint den, inout logic sat);
    logic neg;
    longint unsigned an, ad, q;
    if (den == 0) begin
      sat = 1'b1;
      return (num >= 0) ? 32767 : -32768;
    end
    neg = (num < 0) != (den < 0);
    an = (num < 0) ? -num : num;
    ad = ((den < 0) ? -den : den) << 16;
    q = (an * BAM_SCALE + ad / 2) / ad;
    if (neg) begin
      if (q > 32768) begin
        sat = 1'b1;
        return -32768;
      end
      return -longint'(q);
    end
    if (q > 32767) begin
      sat = 1'b1;
      return 32767;
    end
    return longint'(q);
  endfunction

  task automatic rotate(input longint half, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = GAIN_X0;
    y = 0;
    z = half;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_lut[i];
      end else begin
        x += dx; y -= dy; z += atan_lut[i];
      end
    end
    c = (x + 8192) >>> 14;
    s = (y + 8192) >>> 14;
  endtask

  function automatic logic signed [QUAT_W-1:0] to_q14(longint acc);
    longint v;
    v = (acc + (longint'(1) <<< 33)) >>> 34;
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v[QUAT_W-1:0];
  endfunction

  task automatic predict_attitude(input logic c, input logic signed [15:0] ax, ay, az, hd,
                                  output attitude_t r);
    logic sat;
    longint roll, pitch, cr, sr, cp, sp, cy, sy;
    sat = 1'b0;
    r = '0;
    if (c == CMD_RESTART) begin
      sum_acc = '{0, 0, 0};
      n_samples = 0;
      return;
    end
    if (n_samples < MAX_SAMPLES) begin
      sum_acc[0] += ax;
      sum_acc[1] += ay;
      sum_acc[2] += az;
      n_samples++;
    end
    roll = tilt_angle(sum_acc[1], sum_acc[2], sat);
    pitch = tilt_angle(sum_acc[0], sum_acc[2], sat);
    rotate(roll * 32768, cr, sr);
    rotate(pitch * 32768, cp, sp);
    rotate(longint'(hd) * 32768, cy, sy);
    r.w = to_q14(cr * cp * cy + sr * sp * sy);
    r.x = to_q14(sr * cp * cy - cr * sp * sy);
    r.y = to_q14(cr * sp * cy + sr * cp * sy);
    r.z = to_q14(cr * cp * sy - sr * sp * cy);
    r.sat = sat;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Call at a rising edge; returns at the edge where the word is taken.
  task automatic send_word(input logic c, input logic signed [15:0] ax, ay, az, hd,
                           input int gap);
    attitude_t exp_att;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    accel_x <= ax;
    accel_y <= ay;
    accel_z <= az;
    heading <= hd;
    do @(posedge clk); while (!(in_valid && in_ready));
    predict_attitude(c, ax, ay, az, hd, exp_att);
    pending_attitudes.push_back(exp_att);
  endtask

  task automatic send_sample(input logic signed [15:0] ax, ay, az, hd);
    send_word(CMD_SAMPLE, ax, ay, az, hd, pick_gap());
  endtask

  task automatic send_restart();
    send_word(CMD_RESTART, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              pick_gap());
  endtask

  // Call at a rising edge; drop valid and wait until every result is back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_attitudes.size() != 0) @(posedge clk);
  endtask

  task automatic report(input string what, input int got, input int want);
    mismatches++;
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    attitude_t want;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (pending_attitudes.size() == 0) begin
          report("unexpected word", 0, 0);
        end else begin
          want = pending_attitudes.pop_front();
          if (quat_w !== want.w) report("quat_w", quat_w, want.w);
          if (quat_x !== want.x) report("quat_x", quat_x, want.x);
          if (quat_y !== want.y) report("quat_y", quat_y, want.y);
          if (quat_z !== want.z) report("quat_z", quat_z, want.z);
          if (tilt_saturated !== want.sat) report("tilt_saturated", tilt_saturated, want.sat);
        end
      end
    end
  end

  // output back-pressure: mostly ready, short and long stalls, free-flow stretches
  int stall_left = 0;
  int phase_cycles = 0;
  always @(posedge clk) begin
    int r;
    phase_cycles <= (phase_cycles == 1999) ? 0 : phase_cycles + 1;
    if (phase_cycles < 400) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      out_ready <= (r < 85);
      if (r >= 97) stall_left <= $urandom_range(30, 200);
      else if (r >= 85) stall_left <= $urandom_range(1, 5);
    end
  end

  task automatic test_restart();
    send_restart();
    send_sample(100, -200, 16000, 0);
    send_restart();
    send_sample(0, 0, 0, 0);
  endtask

  task automatic test_zero_z();
    send_restart();
    send_sample(5, -7, 0, 1000);
    send_sample(-5, 7, 0, -1000);
    send_restart();
    send_sample(-1, 0, 0, 0);
  endtask

  task automatic test_angle_overflow();
    send_restart();
    send_sample(32767, -32768, 1, 0);
    send_sample(-32768, 32767, -1, 0);
  endtask

  task automatic test_extremes();
    send_restart();
    send_sample(-32768, -32768, -32768, -32768);
    send_sample(32767, 32767, 32767, 32767);
    send_restart();
    send_sample(0, 0, 32767, -32768);
    send_sample(0, 0, 32767, 32767);
    send_sample(-1, 1, -32768, 16384);
    send_sample(1, -1, -32768, -16384);
  endtask

  task automatic test_idle_then_send();
    drain();
    send_sample(300, 300, 16000, 12345);
    drain();
    send_restart();
  endtask

  task automatic test_averaging_runs(input int runs);
    int len, zmag, spread;
    logic signed [15:0] zs;
    for (int r = 0; r < runs; r++) begin
      send_restart();
      len = $urandom_range(5, 45);
      zmag = $urandom_range(4000, 32767);
      spread = ($urandom_range(0, 9) == 0) ? zmag : zmag / 6;
      for (int k = 0; k < len; k++) begin
        zs = ($urandom_range(0, 3) == 0) ? 16'(-zmag) : 16'(zmag);
        if ($urandom_range(0, 19) == 0)
          send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else
          send_sample(16'($urandom_range(0, 2 * spread) - spread),
                      16'($urandom_range(0, 2 * spread) - spread),
                      16'(zs + $urandom_range(0, 200) - 100), 16'($urandom));
      end
    end
  endtask

  task automatic test_noise(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 15) == 0) send_restart();
      else send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    sum_acc = '{0, 0, 0};
    n_samples = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_restart();
    test_zero_z();
    test_angle_overflow();
    test_extremes();
    test_idle_then_send();
    test_averaging_runs(40);
    test_noise(150);
    drain();
    repeat (150) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
